// File: rtl/btmx_pkg.sv
package btmx_pkg;

  localparam int KEY_BITS  = 30;
  localparam int NODE_W    = 16;
  localparam int MAX_NODES = 1 << NODE_W;
  localparam int FREE_W    = NODE_W + 1;
  localparam int CHK_W     = FREE_W + 1;
  localparam int LINK_W    = 2 * NODE_W;
  localparam int CNT_W     = 17;
  localparam int LVL_W     = $clog2(KEY_BITS + 1);
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic load;
    logic rewind;
    logic step;
    logic acc_bit;
  } dig_ctrl_t;

  typedef struct packed {
    logic             key_bit;
    logic             leaf;
    logic [LVL_W-1:0] lvl;
  } dig_stat_t;

  typedef struct packed {
    logic              idle;
    logic              done;
    logic [STAT_W-1:0] status;
  } walk_stat_t;

endpackage

// File: rtl/btmx_if.sv
interface btmx_req_if;
  import btmx_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

interface btmx_rsp_if;
  import btmx_pkg::*;

  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] best_xor;
  logic [STAT_W-1:0]   status;

  modport source (output valid, output best_xor, output status, input ready);
  modport sink   (input valid, input best_xor, input status, output ready);
endinterface

// File: rtl/btmx_ram.sv
module btmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/btmx_digit.sv
module btmx_digit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  btmx_pkg::dig_ctrl_t           ctrl_i,
  input  logic [btmx_pkg::KEY_BITS-1:0] key_i,
  output btmx_pkg::dig_stat_t           stat_o,
  output logic [btmx_pkg::KEY_BITS-1:0] best_o
);
  import btmx_pkg::*;

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [KEY_BITS-1:0] sh_q, sh_d;
  logic [KEY_BITS-1:0] acc_q, acc_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;

  always_comb begin
    key_d = key_q;
    sh_d  = sh_q;
    acc_d = acc_q;
    lvl_d = lvl_q;
    if (ctrl_i.load) begin
      key_d = key_i;
      sh_d  = key_i;
      acc_d = '0;
      lvl_d = '0;
    end else if (ctrl_i.rewind) begin
      sh_d  = key_q;
      lvl_d = '0;
    end else if (ctrl_i.step) begin
      sh_d  = sh_q << 1;
      acc_d = (acc_q << 1) | KEY_BITS'(ctrl_i.acc_bit);
      lvl_d = lvl_q + LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
    end else begin
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    sh_q  <= sh_d;
    acc_q <= acc_d;
  end

  assign stat_o.key_bit = sh_q[KEY_BITS-1];
  assign stat_o.leaf    = (lvl_q == LVL_W'(KEY_BITS));
  assign stat_o.lvl     = lvl_q;
  assign best_o         = acc_q;

endmodule

// File: rtl/btmx_walk.sv
module btmx_walk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [btmx_pkg::FUNC_W-1:0] func_i,
  input  logic                        fin_ok_i,
  input  btmx_pkg::dig_stat_t         dig_i,
  output btmx_pkg::dig_ctrl_t         dig_o,
  output btmx_pkg::walk_stat_t        stat_o
);
  import btmx_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_START   = 4'd1;
  localparam logic [3:0] S_ICHK_RD = 4'd2;
  localparam logic [3:0] S_ICHK_EV = 4'd3;
  localparam logic [3:0] S_IUPD_RD = 4'd4;
  localparam logic [3:0] S_IUPD_EV = 4'd5;
  localparam logic [3:0] S_INEW    = 4'd6;
  localparam logic [3:0] S_RCHK_RD = 4'd7;
  localparam logic [3:0] S_RCHK_EV = 4'd8;
  localparam logic [3:0] S_RUPD_RD = 4'd9;
  localparam logic [3:0] S_RUPD_EV = 4'd10;
  localparam logic [3:0] S_QLNK_RD = 4'd11;
  localparam logic [3:0] S_QLNK_EV = 4'd12;
  localparam logic [3:0] S_QCNT_EV = 4'd13;
  localparam logic [3:0] S_FIN     = 4'd14;

  function automatic logic [NODE_W-1:0] link_sel(logic [LINK_W-1:0] l, logic b);
    return b ? l[LINK_W-1:NODE_W] : l[NODE_W-1:0];
  endfunction

  function automatic logic [LINK_W-1:0] link_put(logic [LINK_W-1:0] l, logic b,
                                                 logic [NODE_W-1:0] v);
    return b ? {v, l[NODE_W-1:0]} : {l[LINK_W-1:NODE_W], v};
  endfunction

  logic [3:0]        state_q, state_d;
  logic [FUNC_W-1:0] func_q, func_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [NODE_W-1:0] same_q, same_d;
  logic [FREE_W-1:0] free_q, free_d;
  logic [LINK_W-1:0] root_lnk_q, root_lnk_d;
  logic [CNT_W-1:0]  root_cnt_q, root_cnt_d;
  logic              lnk_root_q, lnk_root_d;
  logic              cnt_root_q, cnt_root_d;
  logic [STAT_W-1:0] status_q, status_d;

  logic              lnk_we, lnk_re, lnk_wr;
  logic [NODE_W-1:0] lnk_raddr;
  logic [LINK_W-1:0] lnk_wdata, lnk_rdata, lnk_rd;
  logic              cnt_we, cnt_re, cnt_wr;
  logic [NODE_W-1:0] cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata, cnt_rd;

  logic [NODE_W-1:0] nx, opp;
  logic [CHK_W-1:0]  need_sum;
  logic              over, last;
  logic [LINK_W-1:0] new_link;

  btmx_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (node_q),
    .wdata_i (lnk_wdata),
    .re_i    (lnk_re),
    .raddr_i (lnk_raddr),
    .rdata_o (lnk_rdata)
  );

  btmx_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (node_q),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // root lives in flops, RAM entry zero is never used
  assign lnk_rd = lnk_root_q ? root_lnk_q : lnk_rdata;
  assign cnt_rd = cnt_root_q ? root_cnt_q : cnt_rdata;

  assign nx       = link_sel(lnk_rd, dig_i.key_bit);
  assign opp      = link_sel(lnk_rd, !dig_i.key_bit);
  assign need_sum = {1'b0, free_q} + CHK_W'(KEY_BITS) - CHK_W'(dig_i.lvl);
  assign over     = need_sum > CHK_W'(MAX_NODES);
  assign last     = (dig_i.lvl == LVL_W'(KEY_BITS - 1));
  assign new_link = dig_i.leaf ? '0 :
                    link_put('0, dig_i.key_bit, free_q[NODE_W-1:0]);

  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    node_d     = node_q;
    same_d     = same_q;
    free_d     = free_q;
    root_lnk_d = root_lnk_q;
    root_cnt_d = root_cnt_q;
    lnk_root_d = lnk_root_q;
    cnt_root_d = cnt_root_q;
    status_d   = status_q;
    dig_o      = '0;
    lnk_re     = 1'b0;
    lnk_raddr  = node_q;
    cnt_re     = 1'b0;
    cnt_raddr  = node_q;
    lnk_wr     = 1'b0;
    lnk_wdata  = lnk_rd;
    cnt_wr     = 1'b0;
    cnt_wdata  = cnt_rd;
    lnk_we     = 1'b0;
    cnt_we     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d     = func_i;
          node_d     = '0;
          dig_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        case (func_q)
          FUNC_INSERT: begin
            if (root_cnt_q == CNT_MAX) begin
              status_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              state_d = S_ICHK_RD;
            end
          end
          FUNC_REMOVE: state_d = S_RCHK_RD;
          FUNC_QUERY: begin
            if (root_cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_FIN;
            end else begin
              state_d = S_QLNK_RD;
            end
          end
          default: begin
            status_d = ST_OK;
            state_d  = S_FIN;
          end
        endcase
      end
      S_ICHK_RD: begin
        if (dig_i.leaf) begin
          node_d       = '0;
          dig_o.rewind = 1'b1;
          state_d      = S_IUPD_RD;
        end else begin
          lnk_re     = 1'b1;
          lnk_root_d = (node_q == '0);
          state_d    = S_ICHK_EV;
        end
      end
      S_ICHK_EV: begin
        if (nx == '0) begin
          if (over) begin
            status_d = ST_FULL;
            state_d  = S_FIN;
          end else begin
            node_d       = '0;
            dig_o.rewind = 1'b1;
            state_d      = S_IUPD_RD;
          end
        end else begin
          node_d     = nx;
          dig_o.step = 1'b1;
          state_d    = S_ICHK_RD;
        end
      end
      S_IUPD_RD: begin
        lnk_re     = 1'b1;
        cnt_re     = 1'b1;
        lnk_root_d = (node_q == '0);
        cnt_root_d = (node_q == '0);
        state_d    = S_IUPD_EV;
      end
      S_IUPD_EV: begin
        cnt_wr    = 1'b1;
        cnt_wdata = cnt_rd + CNT_W'(1);
        if (dig_i.leaf) begin
          status_d = ST_OK;
          state_d  = S_FIN;
        end else if (nx == '0) begin
          lnk_wr     = 1'b1;
          lnk_wdata  = link_put(lnk_rd, dig_i.key_bit, free_q[NODE_W-1:0]);
          node_d     = free_q[NODE_W-1:0];
          free_d     = free_q + FREE_W'(1);
          dig_o.step = 1'b1;
          state_d    = S_INEW;
        end else begin
          node_d     = nx;
          dig_o.step = 1'b1;
          state_d    = S_IUPD_RD;
        end
      end
      S_INEW: begin
        lnk_wr    = 1'b1;
        lnk_wdata = new_link;
        cnt_wr    = 1'b1;
        cnt_wdata = CNT_W'(1);
        if (dig_i.leaf) begin
          status_d = ST_OK;
          state_d  = S_FIN;
        end else begin
          node_d     = free_q[NODE_W-1:0];
          free_d     = free_q + FREE_W'(1);
          dig_o.step = 1'b1;
        end
      end
      S_RCHK_RD: begin
        lnk_re     = 1'b1;
        cnt_re     = 1'b1;
        lnk_root_d = (node_q == '0);
        cnt_root_d = (node_q == '0);
        state_d    = S_RCHK_EV;
      end
      S_RCHK_EV: begin
        if (dig_i.leaf) begin
          if (cnt_rd == '0) begin
            status_d = ST_ABSENT;
            state_d  = S_FIN;
          end else begin
            node_d       = '0;
            dig_o.rewind = 1'b1;
            state_d      = S_RUPD_RD;
          end
        end else if (nx == '0) begin
          status_d = ST_ABSENT;
          state_d  = S_FIN;
        end else begin
          node_d     = nx;
          dig_o.step = 1'b1;
          state_d    = S_RCHK_RD;
        end
      end
      S_RUPD_RD: begin
        lnk_re     = 1'b1;
        cnt_re     = 1'b1;
        lnk_root_d = (node_q == '0);
        cnt_root_d = (node_q == '0);
        state_d    = S_RUPD_EV;
      end
      S_RUPD_EV: begin
        cnt_wr    = 1'b1;
        cnt_wdata = cnt_rd - CNT_W'(1);
        if (dig_i.leaf) begin
          status_d = ST_OK;
          state_d  = S_FIN;
        end else begin
          node_d     = nx;
          dig_o.step = 1'b1;
          state_d    = S_RUPD_RD;
        end
      end
      S_QLNK_RD: begin
        lnk_re     = 1'b1;
        lnk_root_d = (node_q == '0);
        state_d    = S_QLNK_EV;
      end
      S_QLNK_EV: begin
        same_d = nx;
        if (opp == '0) begin
          node_d     = nx;
          dig_o.step = 1'b1;
          if (last) begin
            status_d = ST_OK;
            state_d  = S_FIN;
          end else begin
            state_d = S_QLNK_RD;
          end
        end else begin
          cnt_re     = 1'b1;
          cnt_raddr  = opp;
          cnt_root_d = 1'b0;
          node_d     = opp;
          state_d    = S_QCNT_EV;
        end
      end
      S_QCNT_EV: begin
        dig_o.step = 1'b1;
        if (cnt_rd != '0) begin
          dig_o.acc_bit = 1'b1;
        end else begin
          node_d = same_q;
        end
        if (last) begin
          status_d = ST_OK;
          state_d  = S_FIN;
        end else begin
          state_d = S_QLNK_RD;
        end
      end
      S_FIN: begin
        if (fin_ok_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (lnk_wr) begin
      if (node_q == '0) begin
        root_lnk_d = lnk_wdata;
      end else begin
        lnk_we = 1'b1;
      end
    end
    if (cnt_wr) begin
      if (node_q == '0) begin
        root_cnt_d = cnt_wdata;
      end else begin
        cnt_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      free_q     <= FREE_W'(1);
      root_lnk_q <= '0;
      root_cnt_q <= '0;
      lnk_root_q <= 1'b0;
      cnt_root_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      free_q     <= free_d;
      root_lnk_q <= root_lnk_d;
      root_cnt_q <= root_cnt_d;
      lnk_root_q <= lnk_root_d;
      cnt_root_q <= cnt_root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    node_q   <= node_d;
    same_q   <= same_d;
    status_q <= status_d;
  end

  assign stat_o.idle   = (state_q == S_IDLE);
  assign stat_o.done   = (state_q == S_FIN);
  assign stat_o.status = status_q;

endmodule

// File: rtl/binary_trie_max_xor_set.sv
// Channel  Dir  Payload            Transaction
// req_i    in   func, key          valid && ready
// rsp_o    out  best_xor, status   valid && ready
//
// One transaction in, one out. The trie walk issues its node reads level by level and
// uses their data the next cycle through the single read port of each node RAM.
// Insert: a check pass and an update pass over the existing levels, then each new node.
// Remove: a check pass and an update pass over the levels.
// Query: a link read per level, plus a count read of any opposite child. Root sits in flops: no clearing pass.
// A new request is taken while a result waits in the output register.
module binary_trie_max_xor_set (
  input logic         clk_i,
  input logic         rst_ni,
  btmx_req_if.sink    req_i,
  btmx_rsp_if.source  rsp_o
);
  import btmx_pkg::*;

  dig_ctrl_t  dig_ctrl;
  dig_stat_t  dig_stat;
  walk_stat_t wstat;

  logic                accept, slot_free, take;
  logic [KEY_BITS-1:0] best;
  logic                out_vld_q, out_vld_d;
  logic [KEY_BITS-1:0] best_q;
  logic [STAT_W-1:0]   stat_q;

  assign req_i.ready = wstat.idle;
  assign accept      = req_i.valid && req_i.ready;
  assign slot_free   = !out_vld_q || rsp_o.ready;
  assign take        = wstat.done && slot_free;

  btmx_digit u_digit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dig_ctrl),
    .key_i  (req_i.key),
    .stat_o (dig_stat),
    .best_o (best)
  );

  btmx_walk u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .func_i   (req_i.func),
    .fin_ok_i (slot_free),
    .dig_i    (dig_stat),
    .dig_o    (dig_ctrl),
    .stat_o   (wstat)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (take) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q <= best;
      stat_q <= wstat.status;
    end
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.best_xor = best_q;
  assign rsp_o.status   = stat_q;

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni) accept |=> !req_i.ready
  ) else $error("request taken while walk busy");

  a_zero_on_error: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_OK) |-> (rsp_o.best_xor == '0)
  ) else $error("nonzero best_xor with error status");

  a_result_loaded: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    take |=> (rsp_o.valid && rsp_o.status == $past(wstat.status))
  ) else $error("finished walk not presented");

endmodule

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import btmx_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int KEY_POOL_N  = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 200;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [KEY_BITS-1:0] key;
  } trie_op_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] best_xor;
    logic [STAT_W-1:0]   status;
  } trie_answer_t;

  logic clk_i;
  logic rst_ni;

  btmx_req_if req_if ();
  btmx_rsp_if rsp_if ();

  binary_trie_max_xor_set u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow trie
  bit [NODE_W-1:0] trie_kid [MAX_NODES][2];
  bit [CNT_W-1:0]  trie_cnt [MAX_NODES];
  bit [FREE_W-1:0] trie_next = 1;

  trie_op_t     ops_pending [$];
  trie_answer_t answers_due [$];
  logic [KEY_BITS-1:0] key_pool [KEY_POOL_N];

  int send_idle_pct;
  int rsp_idle_pct;
  int n_req_acc;
  int hold_left;
  bit hold_done;
  int quiet_cycles;
  int n_err;

  function automatic logic [STAT_W-1:0] trie_insert(input logic [KEY_BITS-1:0] k);
    int unsigned node;
    int i;
    int need;
    if (trie_cnt[0] == CNT_MAX) return ST_FULL;
    node = 0;
    i = KEY_BITS - 1;
    while (i >= 0 && trie_kid[node][k[i]] != 0) begin
      node = trie_kid[node][k[i]];
      i--;
    end
    need = i + 1;
    if (int'(trie_next) + need > MAX_NODES) return ST_FULL;
    node = 0;
    for (i = KEY_BITS - 1; i >= 0; i--) begin
      trie_cnt[node]++;
      if (trie_kid[node][k[i]] == 0) begin
        trie_kid[node][k[i]] = trie_next[NODE_W-1:0];
        trie_next++;
      end
      node = trie_kid[node][k[i]];
    end
    trie_cnt[node]++;
    return ST_OK;
  endfunction

  function automatic logic [STAT_W-1:0] trie_remove(input logic [KEY_BITS-1:0] k);
    int unsigned node;
    int i;
    node = 0;
    for (i = KEY_BITS - 1; i >= 0; i--) begin
      node = trie_kid[node][k[i]];
      if (node == 0) return ST_ABSENT;
    end
    if (trie_cnt[node] == 0) return ST_ABSENT;
    node = 0;
    for (i = KEY_BITS - 1; i >= 0; i--) begin
      trie_cnt[node]--;
      node = trie_kid[node][k[i]];
    end
    trie_cnt[node]--;
    return ST_OK;
  endfunction

  function automatic logic [STAT_W-1:0] trie_query(input logic [KEY_BITS-1:0] k,
                                                  output logic [KEY_BITS-1:0] best);
    int unsigned node;
    int unsigned opp;
    int i;
    best = '0;
    if (trie_cnt[0] == 0) return ST_EMPTY;
    node = 0;
    for (i = KEY_BITS - 1; i >= 0; i--) begin
      opp = trie_kid[node][!k[i]];
      if (opp != 0 && trie_cnt[opp] != 0) begin
        node    = opp;
        best[i] = 1'b1;
      end else begin
        node = trie_kid[node][k[i]];
      end
    end
    return ST_OK;
  endfunction

  function automatic trie_answer_t trie_apply(input logic [FUNC_W-1:0] func,
                                             input logic [KEY_BITS-1:0] k);
    trie_answer_t a;
    logic [KEY_BITS-1:0] best;
    a.best_xor = '0;
    a.status   = ST_OK;
    case (func)
      FUNC_INSERT: a.status = trie_insert(k);
      FUNC_REMOVE: a.status = trie_remove(k);
      FUNC_QUERY: begin
        a.status   = trie_query(k, best);
        a.best_xor = best;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic void add_op(input logic [FUNC_W-1:0] func,
                                 input logic [KEY_BITS-1:0] k);
    trie_op_t op;
    op.func = func;
    op.key  = k;
    ops_pending = {ops_pending, op};
  endfunction

  // mostly pool keys and near misses so removes hit and queries walk deep
  function automatic void add_random_op();
    int r;
    logic [FUNC_W-1:0] func;
    logic [KEY_BITS-1:0] k;
    r = $urandom_range(99);
    if (r < 40)      func = FUNC_INSERT;
    else if (r < 65) func = FUNC_REMOVE;
    else if (r < 95) func = FUNC_QUERY;
    else             func = FUNC_SPARE;
    r = $urandom_range(99);
    k = key_pool[$urandom_range(KEY_POOL_N - 1)];
    if (r < 25)      k = KEY_BITS'($urandom);
    else if (r < 45) k = k ^ (KEY_BITS'(1) << $urandom_range(KEY_BITS - 1));
    add_op(func, k);
  endfunction

  task automatic wait_settled();
    while (ops_pending.size() != 0 || req_if.valid || answers_due.size() != 0)
      @(posedge clk_i);
  endtask

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive
    trie_op_t op;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.func  <= FUNC_INSERT;
      req_if.key   <= '0;
      n_req_acc    <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        answers_due = {answers_due, trie_apply(req_if.func, req_if.key)};
        n_req_acc <= n_req_acc + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (ops_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op = ops_pending.pop_front();
          req_if.valid <= 1'b1;
          req_if.func  <= op.func;
          req_if.key   <= op.key;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response ready, with one long hold-off early in the run
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && n_req_acc >= 30) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= LONG_HOLD;
      hold_done    <= 1'b1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // response checker
  always @(posedge clk_i) begin : check
    trie_answer_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected transaction: best_xor %h status %0d",
               rsp_if.best_xor, rsp_if.status);
        n_err++;
      end else begin
        want = answers_due.pop_front();
        if (rsp_if.best_xor !== want.best_xor) begin
          $error("best_xor mismatch: expected %h, got %h", want.best_xor, rsp_if.best_xor);
          n_err++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, rsp_if.status);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no transaction for %0d cycles", QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int i;
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.func   = FUNC_INSERT;
    req_if.key    = '0;
    rsp_if.ready  = 1'b0;
    n_err         = 0;
    quiet_cycles  = 0;
    send_idle_pct = 20;
    rsp_idle_pct  = 74;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < KEY_POOL_N; i++) key_pool[i] = KEY_BITS'($urandom);

    // empty set, absent keys, spare code
    add_op(FUNC_QUERY,  '0);
    add_op(FUNC_REMOVE, '1);
    add_op(FUNC_SPARE,  '1);
    add_op(FUNC_SPARE,  '0);
    // extremes and duplicates
    add_op(FUNC_INSERT, '0);
    add_op(FUNC_INSERT, '1);
    add_op(FUNC_INSERT, '0);
    add_op(FUNC_QUERY,  '0);
    add_op(FUNC_QUERY,  '1);
    add_op(FUNC_QUERY,  30'h2AAA_AAAA);
    // path missing partway down
    add_op(FUNC_REMOVE, 30'h0000_0001);
    add_op(FUNC_REMOVE, '1);
    // path present, leaf count zero
    add_op(FUNC_REMOVE, '1);
    // opposite child exists but is dead
    add_op(FUNC_QUERY,  '0);
    add_op(FUNC_REMOVE, '0);
    add_op(FUNC_REMOVE, '0);
    add_op(FUNC_REMOVE, '0);
    // empty again with nodes allocated
    add_op(FUNC_QUERY,  30'h1555_5555);
    add_op(FUNC_INSERT, 30'h2000_0000);
    add_op(FUNC_INSERT, 30'h1FFF_FFFF);
    add_op(FUNC_QUERY,  30'h2000_0000);
    add_op(FUNC_QUERY,  30'h1555_5555);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    repeat (140) add_random_op();
    wait_settled();

    send_idle_pct = 74;
    rsp_idle_pct  = 20;
    repeat (140) add_random_op();
    wait_settled();

    send_idle_pct = 0;
    rsp_idle_pct  = 0;
    repeat (140) add_random_op();
    wait_settled();

    repeat (12) add_random_op();
    wait_settled();

    repeat (SETTLE) @(posedge clk_i);
    if (answers_due.size() != 0) begin
      $error("%0d transactions never arrived", answers_due.size());
      n_err++;
    end
    if (n_err == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
